@@ hw/rtl/sd_spi_mode_host_sequencer_core_macros.svh @@
// Assertion macros for the SD SPI-mode host sequencer.
// Used by the top level; no other dependencies.
`ifndef SD_SPI_MODE_HOST_SEQUENCER_CORE_MACROS_SVH
`define SD_SPI_MODE_HOST_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTH
// The condition must never be true outside reset.
`define SDSH_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("violated");
// The first expression implies the second at the same edge.
`define SDSH_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("violated");
`else
`define SDSH_NEVER(label, clk, rst, cond)
`define SDSH_IMPLY(label, clk, rst, a, b)
`endif
`endif

@@ hw/rtl/sdsh_pkg.sv @@
// Package for the SD SPI-mode host sequencer: word types and codes.
// No dependencies.
package sdsh_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int BPOS_W       = 10;
   localparam logic [BPOS_W-1:0] LAST_BYTE = BPOS_W'(SECTOR_BYTES - 1);

   // Request codes.
   localparam logic [2:0] REQ_INIT  = 3'd0;
   localparam logic [2:0] REQ_READ  = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_DONE  = 3'd3;
   localparam logic [2:0] REQ_WBYTE = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_XFER = 2'd0;
   localparam logic [1:0] KIND_RD   = 2'd1;
   localparam logic [1:0] KIND_NEED = 2'd2;
   localparam logic [1:0] KIND_FIN  = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_IDLE  = 3'd1;
   localparam logic [2:0] ST_INIT_TO  = 3'd2;
   localparam logic [2:0] ST_CMD_REJ  = 3'd3;
   localparam logic [2:0] ST_TOKEN_TO = 3'd4;
   localparam logic [2:0] ST_DATA_REJ = 3'd5;
   localparam logic [2:0] ST_BUSY_TO  = 3'd6;
   localparam logic [2:0] ST_BAD_REQ  = 3'd7;

   // Configuration register indexes.
   localparam logic [2:0] REG_WAKE   = 3'd0;
   localparam logic [2:0] REG_RPOLL  = 3'd1;
   localparam logic [2:0] REG_TPOLL  = 3'd2;
   localparam logic [2:0] REG_RETRY  = 3'd3;
   localparam logic [2:0] REG_BPOLL  = 3'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] sector;
      logic [15:0] block_count;
      logic [7:0]  rx_byte;
      logic [7:0]  wr_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] tx_byte;
      logic       cs_low;
      logic       fast_clock;
      logic [7:0] rd_byte;
      logic       sector_end;
      logic [2:0] status;
      logic       last;
   } rsp_word_type;

endpackage

@@ hw/rtl/sd_spi_mode_host_sequencer_core.sv @@
// SD-card SPI-mode host sequencer: one state transition per accepted word.
// Depends on sdsh_pkg and sd_spi_mode_host_sequencer_core_macros.svh.
//
// Usage: the host sends a request word (init, read, write) on the req_
// channel, then answers each "perform exchange" result with an "exchange
// done" word carrying the received byte, and each "need write byte" result
// with a write data byte word. Results leave on the rsp_ channel; every
// request word yields one result, or two while sector data is read (the data
// byte, then the next exchange). The last result of a word has last set.
// A word accepted at an edge has its first result registered and valid in the
// next cycle. Throughput: one word per cycle; results pass through a
// four-word output queue, and req_stall rises when fewer than two slots are
// free, so a word that yields two results takes two queue slots.
// When the receiver stalls, results wait in the queue and the input is
// stalled once the queue cannot hold two more.
// Reset: phase idle, chip select released, slow clock, registers at their
// defaults, queue empty. Registers are on the csr_ port at 4*index.
`include "sd_spi_mode_host_sequencer_core_macros.svh"
module sd_spi_mode_host_sequencer_core
   import sdsh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [3:0] PH_IDLE = 4'd0,  PH_WAKE = 4'd1,  PH_FRAME = 4'd2,
                          PH_POLL = 4'd3,  PH_R7 = 4'd4,    PH_TOKEN = 4'd5,
                          PH_RDATA = 4'd6, PH_RCRC = 4'd7,  PH_RTAIL = 4'd8,
                          PH_WGAP = 4'd9,  PH_WTOKEN = 4'd10, PH_WNEED = 4'd11,
                          PH_WDATA = 4'd12, PH_WCRC = 4'd13, PH_WRESP = 4'd14,
                          PH_WBUSY = 4'd15;

   // Configuration registers.
   logic [7:0]  wake_ff, rpoll_ff;
   logic [15:0] tpoll_ff;
   logic [11:0] retry_lim_ff;
   logic [23:0] bpoll_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_ff      <= 8'd10;
         rpoll_ff     <= 8'd10;
         tpoll_ff     <= 16'd1000;
         retry_lim_ff <= 12'd2000;
         bpoll_ff     <= 24'd65535;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WAKE:  wake_ff      <= csr_pwdata[7:0];
            REG_RPOLL: rpoll_ff     <= csr_pwdata[7:0];
            REG_TPOLL: tpoll_ff     <= csr_pwdata[15:0];
            REG_RETRY: retry_lim_ff <= csr_pwdata[11:0];
            REG_BPOLL: bpoll_ff     <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_idx)
         REG_WAKE:  csr_prdata = {24'd0, wake_ff};
         REG_RPOLL: csr_prdata = {24'd0, rpoll_ff};
         REG_TPOLL: csr_prdata = {16'd0, tpoll_ff};
         REG_RETRY: csr_prdata = {20'd0, retry_lim_ff};
         REG_BPOLL: csr_prdata = {8'd0, bpoll_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // Limits, where zero acts as one.
   logic [7:0]  wake_lim, rpoll_lim;
   logic [15:0] tpoll_lim;
   logic [11:0] retry_lim;
   logic [23:0] bpoll_lim;
   assign wake_lim  = (wake_ff == 8'd0) ? 8'd1 : wake_ff;
   assign rpoll_lim = (rpoll_ff == 8'd0) ? 8'd1 : rpoll_ff;
   assign tpoll_lim = (tpoll_ff == 16'd0) ? 16'd1 : tpoll_ff;
   assign retry_lim = (retry_lim_ff == 12'd0) ? 12'd1 : retry_lim_ff;
   assign bpoll_lim = (bpoll_ff == 24'd0) ? 24'd1 : bpoll_ff;

   // Sequencer state.
   logic [3:0]        phase_ff, phase_in;
   logic [1:0]        pend_ff, pend_in;
   logic [5:0]        cmd_ff, cmd_in;
   logic [31:0]       arg_ff, arg_in;
   logic [2:0]        fpos_ff, fpos_in;
   logic [31:0]       cur_ff, cur_in;
   logic [15:0]       left_ff, left_in;
   logic [BPOS_W-1:0] bpos_ff, bpos_in;
   logic [23:0]       poll_ff, poll_in;
   logic [11:0]       retry_ff, retry_in;
   logic              fast_ff, fast_in, cs_ff, cs_in;

   // Output queue.
   rsp_word_type q_ff [4];
   logic [1:0]   wptr_ff, rptr_ff;
   logic [2:0]   cnt_ff;

   logic         acc, pop;
   logic [1:0]   nres;
   rsp_word_type res0, res1;

   assign req_stall = (cnt_ff > 3'd2);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_word  = q_ff[rptr_ff];

   // Byte of the command frame at a given position.
   function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] cmd,
                                             input logic [31:0] arg);
      logic [7:0] b;
      unique case (pos)
         3'd1: b = {2'b01, cmd};
         3'd2: b = arg[31:24];
         3'd3: b = arg[23:16];
         3'd4: b = arg[15:8];
         3'd5: b = arg[7:0];
         default: b = (cmd == 6'd0) ? 8'h95 : ((cmd == 6'd8) ? 8'h87 : 8'h01);
      endcase
      return b;
   endfunction

   // Next state and results for the accepted word.
   always_comb begin
      logic        xf, fin, bad, need, rdv, rend, cresp, sec, stc;
      logic [7:0]  xf_tx, rx, rdb;
      logic [2:0]  fst;
      logic [5:0]  stc_cmd;
      logic [31:0] stc_arg;
      logic [23:0] pinc;
      logic [BPOS_W-1:0] binc;

      phase_in = phase_ff; pend_in = pend_ff; cmd_in = cmd_ff; arg_in = arg_ff;
      fpos_in = fpos_ff; cur_in = cur_ff; left_in = left_ff; bpos_in = bpos_ff;
      poll_in = poll_ff; retry_in = retry_ff; fast_in = fast_ff; cs_in = cs_ff;
      xf = 1'b0; fin = 1'b0; bad = 1'b0; need = 1'b0; rdv = 1'b0; rend = 1'b0;
      cresp = 1'b0; sec = 1'b0; stc = 1'b0;
      xf_tx = 8'hFF; fst = ST_OK; stc_cmd = 6'd0; stc_arg = 32'd0;
      rx = req_word.rx_byte; rdb = rx;
      pinc = poll_ff + 24'd1;
      binc = bpos_ff + BPOS_W'(1);

      if (acc) begin
         if (phase_ff == PH_IDLE) begin
            if (req_word.req_type == REQ_INIT) begin
               pend_in = 2'd1; fast_in = 1'b0; cs_in = 1'b0;
               bpos_in = '0; phase_in = PH_WAKE; xf = 1'b1;
            end else if (req_word.req_type == REQ_READ || req_word.req_type == REQ_WRITE) begin
               pend_in = req_word.req_type[1:0] + 2'd1;
               cur_in  = req_word.sector;
               left_in = req_word.block_count;
               sec     = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end else if (req_word.req_type == REQ_DONE && phase_ff != PH_WNEED) begin
            unique case (phase_ff)
               PH_WAKE: begin
                  bpos_in = binc;
                  if (binc < BPOS_W'(wake_lim)) xf = 1'b1;
                  else begin stc = 1'b1; stc_cmd = 6'd0; stc_arg = 32'd0; end
               end
               PH_FRAME: begin
                  if (fpos_ff < 3'd6) begin
                     fpos_in = fpos_ff + 3'd1; cs_in = 1'b1; xf = 1'b1;
                     xf_tx = frame_byte(fpos_ff + 3'd1, cmd_ff, arg_ff);
                  end else begin
                     phase_in = PH_POLL; poll_in = '0; xf = 1'b1;
                  end
               end
               PH_POLL: begin
                  poll_in = pinc;
                  if (rx[7] && pinc < 24'(rpoll_lim)) xf = 1'b1;
                  else cresp = 1'b1;
               end
               PH_R7: begin
                  if (bpos_ff < BPOS_W'(3)) begin bpos_in = binc; xf = 1'b1; end
                  else begin
                     cs_in = 1'b0; retry_in = '0;
                     stc = 1'b1; stc_cmd = 6'd55; stc_arg = 32'd0;
                  end
               end
               PH_TOKEN: begin
                  poll_in = pinc;
                  if (rx == 8'hFE) begin phase_in = PH_RDATA; bpos_in = '0; xf = 1'b1; end
                  else if (pinc < 24'(tpoll_lim)) xf = 1'b1;
                  else begin cs_in = 1'b0; fin = 1'b1; fst = ST_TOKEN_TO; end
               end
               PH_RDATA: begin
                  rdv  = 1'b1;
                  rend = (bpos_ff == LAST_BYTE);
                  if (bpos_ff >= LAST_BYTE) begin phase_in = PH_RCRC; bpos_in = '0; end
                  else bpos_in = binc;
                  xf = 1'b1;
               end
               PH_RCRC: begin
                  if (bpos_ff == '0) bpos_in = BPOS_W'(1);
                  else begin cs_in = 1'b0; phase_in = PH_RTAIL; end
                  xf = 1'b1;
               end
               PH_RTAIL: begin
                  cur_in = cur_ff + 32'd1; left_in = left_ff - 16'd1; sec = 1'b1;
               end
               PH_WGAP: begin phase_in = PH_WTOKEN; xf = 1'b1; xf_tx = 8'hFE; end
               PH_WTOKEN: begin phase_in = PH_WNEED; bpos_in = '0; need = 1'b1; end
               PH_WDATA: begin
                  if (bpos_ff >= LAST_BYTE) begin
                     phase_in = PH_WCRC; bpos_in = '0; xf = 1'b1;
                  end else begin
                     bpos_in = binc; phase_in = PH_WNEED; need = 1'b1;
                  end
               end
               PH_WCRC: begin
                  if (bpos_ff == '0) bpos_in = BPOS_W'(1);
                  else phase_in = PH_WRESP;
                  xf = 1'b1;
               end
               PH_WRESP: begin
                  if (rx[4:0] != 5'h05) begin cs_in = 1'b0; fin = 1'b1; fst = ST_DATA_REJ; end
                  else begin phase_in = PH_WBUSY; poll_in = '0; xf = 1'b1; end
               end
               PH_WBUSY: begin
                  poll_in = pinc;
                  if (rx != 8'h00) begin
                     cs_in = 1'b0; cur_in = cur_ff + 32'd1; left_in = left_ff - 16'd1;
                     sec = 1'b1;
                  end else if (pinc < bpoll_lim) xf = 1'b1;
                  else begin cs_in = 1'b0; fin = 1'b1; fst = ST_BUSY_TO; end
               end
               default: bad = 1'b1;
            endcase
         end else if (req_word.req_type == REQ_WBYTE && phase_ff == PH_WNEED) begin
            phase_in = PH_WDATA; xf = 1'b1; xf_tx = req_word.wr_byte;
         end else begin
            bad = 1'b1;
         end
      end

      // Command response handling.
      if (cresp) begin
         unique case (cmd_ff)
            6'd0: begin
               cs_in = 1'b0;
               if (rx != 8'h01) begin fin = 1'b1; fst = ST_NO_IDLE; end
               else begin stc = 1'b1; stc_cmd = 6'd8; stc_arg = 32'h0000_01AA; end
            end
            6'd8: begin
               if (rx == 8'h01) begin phase_in = PH_R7; bpos_in = '0; xf = 1'b1; end
               else begin
                  cs_in = 1'b0; retry_in = '0;
                  stc = 1'b1; stc_cmd = 6'd55; stc_arg = 32'd0;
               end
            end
            6'd55: begin stc = 1'b1; stc_cmd = 6'd41; stc_arg = 32'h4000_0000; end
            6'd41: begin
               cs_in = 1'b0;
               if (rx == 8'h00) begin fast_in = 1'b1; fin = 1'b1; fst = ST_OK; end
               else begin
                  retry_in = retry_ff + 12'd1;
                  if (retry_in >= retry_lim) begin fin = 1'b1; fst = ST_INIT_TO; end
                  else begin stc = 1'b1; stc_cmd = 6'd55; stc_arg = 32'd0; end
               end
            end
            6'd17, 6'd24: begin
               if (rx != 8'h00) begin cs_in = 1'b0; fin = 1'b1; fst = ST_CMD_REJ; end
               else if (cmd_ff == 6'd17) begin
                  phase_in = PH_TOKEN; poll_in = '0; xf = 1'b1;
               end else begin
                  phase_in = PH_WGAP; xf = 1'b1;
               end
            end
            default: begin cs_in = 1'b0; fin = 1'b1; fst = ST_BAD_REQ; end
         endcase
      end

      // Next sector command or completion.
      if (sec) begin
         if (left_in == 16'd0) begin fin = 1'b1; fst = ST_OK; end
         else begin
            stc = 1'b1; stc_cmd = (pend_in == 2'd2) ? 6'd17 : 6'd24; stc_arg = cur_in;
         end
      end

      // Command start: leading 0xFF, then the frame.
      if (stc) begin
         cmd_in = stc_cmd; arg_in = stc_arg; fpos_in = '0; phase_in = PH_FRAME;
         xf = 1'b1; xf_tx = 8'hFF;
      end
      if (fin) begin phase_in = PH_IDLE; pend_in = 2'd0; end

      // Result words.
      res0 = '0; res1 = '0;
      res1.cs_low = cs_in; res1.fast_clock = fast_in; res1.last = 1'b1;
      if (xf) begin res1.out_kind = KIND_XFER; res1.tx_byte = xf_tx; end
      else if (need) res1.out_kind = KIND_NEED;
      else begin res1.out_kind = KIND_FIN; res1.status = bad ? ST_BAD_REQ : fst; end
      res0.out_kind = KIND_RD; res0.cs_low = cs_in; res0.fast_clock = fast_in;
      res0.rd_byte = rdb; res0.sector_end = rend;
      if (!rdv) begin res0 = res1; end
      nres = !acc ? 2'd0 : (rdv ? 2'd2 : 2'd1);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; pend_ff <= '0; cmd_ff <= '0; arg_ff <= '0;
         fpos_ff <= '0; cur_ff <= '0; left_ff <= '0; bpos_ff <= '0;
         poll_ff <= '0; retry_ff <= '0; fast_ff <= 1'b0; cs_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pend_ff <= pend_in; cmd_ff <= cmd_in; arg_ff <= arg_in;
         fpos_ff <= fpos_in; cur_ff <= cur_in; left_ff <= left_in; bpos_ff <= bpos_in;
         poll_ff <= poll_in; retry_ff <= retry_in; fast_ff <= fast_in; cs_ff <= cs_in;
      end
   end

   // Output queue payload.
   always_ff @(posedge clock) begin
      if (nres != 2'd0) q_ff[wptr_ff] <= res0;
      if (nres == 2'd2) q_ff[wptr_ff + 2'd1] <= res1;
   end

   // Output queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0; rptr_ff <= '0; cnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_ff + nres;
         rptr_ff <= rptr_ff + {1'b0, pop};
         cnt_ff  <= cnt_ff + {1'b0, nres} - {2'b00, pop};
      end
   end

   `SDSH_NEVER(a_queue_overflow, clock, reset, cnt_ff > 3'd4)
   `SDSH_IMPLY(a_idle_cs_released, clock, reset, phase_ff == PH_IDLE, !cs_ff)
   `SDSH_IMPLY(a_idle_no_pending, clock, reset, phase_ff == PH_IDLE, pend_ff == 2'd0)

endmodule
